FILE: hw/rtl/plob_pkg.sv
package plob_pkg;

    localparam int ORDER_SLOTS = 4096;
    localparam int LEVEL_SLOTS = 256;
    localparam int OA_W        = $clog2(ORDER_SLOTS);
    localparam int LA_W        = $clog2(LEVEL_SLOTS);
    localparam int ID_EXT_W    = 17;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_IN_USE  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] UPD_NONE  = 2'd0;
    localparam logic [1:0] UPD_ERR   = 2'd1;
    localparam logic [1:0] UPD_BACK  = 2'd2;
    localparam logic [1:0] UPD_PLACE = 2'd3;

    typedef struct packed {
        logic        live;
        logic [8:0]  symside;
        logic [31:0] price;
        logic [23:0] qty;
    } ord_rec_t;

    typedef struct packed {
        logic [40:0] key;
        logic [31:0] sum;
        logic [12:0] cnt;
    } lvl_rec_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [40:0] key;
        logic [31:0] total;
        logic [12:0] orders;
        logic        last;
    } plob_res_t;

    typedef struct packed {
        logic       clear;
        logic       accept;
        logic       key_input;
        logic       key_record;
        logic       scan_start;
        logic       scan;
        logic [1:0] upd;
        logic [1:0] err_code;
        logic       load_out;
    } plob_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] mode;
        logic       known;
        logic       live;
        logic       scan_done;
        logic       out_free;
        logic       res_last;
    } plob_sts_t;

endpackage

FILE: hw/rtl/plob_if.sv
interface plob_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  symbol;
    logic        side;
    logic [11:0] order_id;
    logic [23:0] order_size;
    logic [31:0] price;

    modport source (output valid, mode, symbol, side, order_id, order_size, price,
                    input ready);
    modport sink   (input valid, mode, symbol, side, order_id, order_size, price,
                    output ready);
endinterface

interface plob_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  level_symbol;
    logic        level_side;
    logic [31:0] level_price;
    logic [31:0] level_total;
    logic [12:0] level_orders;
    logic        last;

    modport source (output valid, status, level_symbol, level_side, level_price,
                    level_total, level_orders, last, input ready);
    modport sink   (input valid, status, level_symbol, level_side, level_price,
                    level_total, level_orders, last, output ready);
endinterface

FILE: hw/rtl/plob_ctrl.sv
module plob_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_mode,
    output logic               req_ready,
    input  plob_pkg::plob_sts_t sts,
    output plob_pkg::plob_cmd_t cmd
);
    import plob_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ORD   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       place_reg, place_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            place_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            place_reg <= place_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        place_next = place_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_mode != MODE_NONE)
                        state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                if (sts.mode == MODE_ADD)
                begin
                    priority if (!sts.known)
                    begin
                        cmd.upd      = UPD_ERR;
                        cmd.err_code = ST_UNKNOWN;
                        state_next   = S_EMIT;
                    end
                    else if (sts.live)
                    begin
                        cmd.upd      = UPD_ERR;
                        cmd.err_code = ST_IN_USE;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        cmd.key_input  = 1'b1;
                        cmd.scan_start = 1'b1;
                        place_next     = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else
                begin
                    if (!sts.known || !sts.live)
                    begin
                        cmd.upd      = UPD_ERR;
                        cmd.err_code = ST_UNKNOWN;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        cmd.key_record = 1'b1;
                        cmd.scan_start = 1'b1;
                        place_next     = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = place_reg ? UPD_PLACE : UPD_BACK;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.res_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        place_next     = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/plob_dp.sv
module plob_dp (
    input  logic               clk,
    input  logic               rst_n,
    plob_req_if.sink           req,
    plob_rsp_if.source         rsp,
    input  plob_pkg::plob_cmd_t cmd,
    output plob_pkg::plob_sts_t sts
);
    import plob_pkg::*;

    localparam logic [ID_EXT_W-1:0] ID_LIMIT  = ID_EXT_W'(ORDER_SLOTS);
    localparam logic [OA_W-1:0]     CLR_LAST  = OA_W'(ORDER_SLOTS - 1);
    localparam logic [LA_W:0]       SCAN_END  = (LA_W + 1)'(LEVEL_SLOTS);

    ord_rec_t ord_mem [ORDER_SLOTS];
    lvl_rec_t lvl_mem [LEVEL_SLOTS];

    logic [1:0]       mode_reg;
    logic [8:0]       symside_reg;
    logic [OA_W-1:0]  id_reg;
    logic             known_reg;
    logic [23:0]      size_reg;
    logic [31:0]      price_reg;
    ord_rec_t         ord_rd_reg;
    lvl_rec_t         lvl_rd_reg;
    logic [OA_W-1:0]  clr_reg;
    logic [40:0]      key_reg;
    logic [LA_W:0]    scan_reg;
    logic             chk_valid_reg;
    logic [LA_W-1:0]  chk_idx_reg;
    logic             hit_reg;
    logic [LA_W-1:0]  hit_idx_reg;
    logic [31:0]      hit_sum_reg;
    logic [12:0]      hit_cnt_reg;
    logic             free_reg;
    logic [LA_W-1:0]  free_idx_reg;
    logic [LEVEL_SLOTS-1:0] used_reg;
    plob_res_t        res_reg;
    plob_res_t        out_reg;
    logic             out_valid_reg;

    logic [ID_EXT_W-1:0] id_ext;
    logic             scan_rd;
    logic [LA_W-1:0]  place_idx;
    logic [31:0]      base_sum;
    logic [12:0]      base_cnt;
    logic [32:0]      sum_add;
    logic [31:0]      sat_sum;
    logic [12:0]      inc_cnt;
    logic [31:0]      back_sum;
    logic [12:0]      back_cnt;
    logic             place_ok;
    logic             ord_we;
    logic [OA_W-1:0]  ord_wa;
    ord_rec_t         ord_wd;
    logic             lvl_we;
    logic [LA_W-1:0]  lvl_wa;

    assign id_ext    = ID_EXT_W'(req.order_id);
    assign scan_rd   = cmd.scan && (scan_reg != SCAN_END);
    assign place_ok  = hit_reg || free_reg;
    assign place_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    assign base_sum  = hit_reg ? hit_sum_reg : 32'd0;
    assign base_cnt  = hit_reg ? hit_cnt_reg : 13'd0;
    assign sum_add   = {1'b0, base_sum} + 33'(size_reg);
    assign sat_sum   = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
    assign inc_cnt   = base_cnt + 13'd1;
    assign back_sum  = (32'(ord_rd_reg.qty) > hit_sum_reg) ? 32'd0
                     : hit_sum_reg - 32'(ord_rd_reg.qty);
    assign back_cnt  = (hit_cnt_reg != 13'd0) ? hit_cnt_reg - 13'd1 : 13'd0;

    always_comb
    begin
        ord_we = 1'b0;
        ord_wa = id_reg;
        ord_wd = ord_rd_reg;
        lvl_we = 1'b0;
        lvl_wa = place_idx;
        if (cmd.clear)
        begin
            ord_we = 1'b1;
            ord_wa = clr_reg;
            ord_wd = '0;
        end
        else if (cmd.upd == UPD_PLACE)
        begin
            ord_we = 1'b1;
            ord_wd = '{live: place_ok, symside: key_reg[40:32], price: key_reg[31:0],
                       qty: size_reg};
            lvl_we = place_ok;
        end
        else if (cmd.upd == UPD_BACK)
        begin
            ord_we      = (mode_reg == MODE_DELETE);
            ord_wd.live = 1'b0;
            lvl_we      = hit_reg;
            lvl_wa      = hit_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        if (cmd.accept)
            ord_rd_reg <= ord_mem[id_ext[OA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            if (cmd.upd == UPD_PLACE)
                lvl_mem[lvl_wa] <= '{key: key_reg, sum: sat_sum, cnt: inc_cnt};
            else
                lvl_mem[lvl_wa] <= '{key: key_reg, sum: back_sum, cnt: back_cnt};
        end
        if (scan_rd)
            lvl_rd_reg <= lvl_mem[scan_reg[LA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg    <= req.mode;
            symside_reg <= {req.symbol, req.side};
            id_reg      <= id_ext[OA_W-1:0];
            known_reg   <= (id_ext < ID_LIMIT);
            size_reg    <= req.order_size;
            price_reg   <= req.price;
        end
        if (cmd.key_input)
            key_reg <= {symside_reg, price_reg};
        else if (cmd.key_record)
            key_reg <= {ord_rd_reg.symside, ord_rd_reg.price};
        else if (cmd.upd == UPD_BACK)
            key_reg <= {key_reg[40:32], price_reg};
        if (scan_rd)
            chk_idx_reg <= scan_reg[LA_W-1:0];
        if (cmd.scan && chk_valid_reg)
        begin
            if (used_reg[chk_idx_reg] && (lvl_rd_reg.key == key_reg) && !hit_reg)
            begin
                hit_idx_reg <= chk_idx_reg;
                hit_sum_reg <= lvl_rd_reg.sum;
                hit_cnt_reg <= lvl_rd_reg.cnt;
            end
            if (!used_reg[chk_idx_reg] && !free_reg)
                free_idx_reg <= chk_idx_reg;
        end
        unique case (cmd.upd)
            UPD_ERR:
            begin
                res_reg.status <= cmd.err_code;
                res_reg.key    <= (mode_reg == MODE_ADD) ? {symside_reg, price_reg} : '0;
                res_reg.total  <= '0;
                res_reg.orders <= '0;
                res_reg.last   <= 1'b1;
            end
            UPD_PLACE:
            begin
                res_reg.status <= place_ok ? ST_OK : ST_FULL;
                res_reg.key    <= key_reg;
                res_reg.total  <= place_ok ? sat_sum : 32'd0;
                res_reg.orders <= place_ok ? inc_cnt : 13'd0;
                res_reg.last   <= 1'b1;
            end
            UPD_BACK:
            begin
                res_reg.status <= ST_OK;
                res_reg.key    <= key_reg;
                res_reg.total  <= hit_reg ? back_sum : 32'd0;
                res_reg.orders <= hit_reg ? back_cnt : 13'd0;
                res_reg.last   <= (mode_reg != MODE_MODIFY);
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (cmd.load_out)
            out_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
                clr_reg <= clr_reg + OA_W'(1);
            if (cmd.scan_start)
            begin
                scan_reg      <= '0;
                chk_valid_reg <= 1'b0;
                hit_reg       <= 1'b0;
                free_reg      <= 1'b0;
            end
            else if (cmd.scan)
            begin
                chk_valid_reg <= scan_rd;
                if (scan_rd)
                    scan_reg <= scan_reg + (LA_W + 1)'(1);
                if (chk_valid_reg)
                begin
                    if (used_reg[chk_idx_reg] && (lvl_rd_reg.key == key_reg))
                        hit_reg <= 1'b1;
                    if (!used_reg[chk_idx_reg])
                        free_reg <= 1'b1;
                end
            end
            if (lvl_we)
            begin
                if (cmd.upd == UPD_PLACE)
                    used_reg[lvl_wa] <= 1'b1;
                else if (back_cnt == 13'd0)
                    used_reg[lvl_wa] <= 1'b0;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.clr_done  = cmd.clear && (clr_reg == CLR_LAST);
    assign sts.mode      = mode_reg;
    assign sts.known     = known_reg;
    assign sts.live      = ord_rd_reg.live;
    assign sts.scan_done = (scan_reg == SCAN_END) && !chk_valid_reg;
    assign sts.out_free  = !out_valid_reg || rsp.ready;
    assign sts.res_last  = res_reg.last;

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.level_symbol = out_reg.key[40:33];
    assign rsp.level_side   = out_reg.key[32];
    assign rsp.level_price  = out_reg.key[31:0];
    assign rsp.level_total  = out_reg.total;
    assign rsp.level_orders = out_reg.orders;
    assign rsp.last         = out_reg.last;

endmodule

FILE: hw/rtl/price_level_order_book.sv
// Channel  Dir  Carries
// -------  ---  --------------------------------------------------------
// req      in   mode, symbol, side, order_id, order_size, price
// rsp      out  status, level_symbol/side/price, level_total/orders, last
//
// One request at a time. Add and delete each run one key search of the level table,
// one memory entry per cycle; modify runs two, taking the order off its old level
// and then placing it. Rejected requests skip the search; mode 3 gives no result.
// After reset the order table is cleared, with req.ready low.
// A stalled rsp holds the block only when a further result is ready to go out.
module price_level_order_book (
    input  logic       clk,
    input  logic       rst_n,
    plob_req_if.sink   req,
    plob_rsp_if.source rsp
);
    import plob_pkg::*;

    plob_cmd_t cmd;
    plob_sts_t sts;

    plob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    plob_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

FILE: hw/rtl/plob_chk.sv
module plob_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_level_total,
    input logic [12:0] rsp_level_orders,
    input logic        rsp_last
);
    import plob_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp dropped while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> rsp_last)
        else $error("error result not final");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK)
        |-> (rsp_level_total == 32'd0) && (rsp_level_orders == 13'd0))
        else $error("error result carries level totals");

    a_orders_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_OK) && rsp_last && (rsp_level_orders == 13'd0)
        |-> (rsp_level_total == 32'd0))
        else $error("empty level with nonzero total");

endmodule

bind price_level_order_book plob_chk u_plob_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_level_total  (rsp.level_total),
    .rsp_level_orders (rsp.level_orders),
    .rsp_last         (rsp.last)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import plob_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    plob_req_if req ();
    plob_rsp_if rsp ();

    price_level_order_book dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  symbol;
        logic        side;
        logic [31:0] price;
        logic [31:0] total;
        logic [12:0] orders;
        logic        last;
    } level_report_t;

    bit          book_live [ORDER_SLOTS];
    logic [8:0]  book_symside [ORDER_SLOTS];
    logic [31:0] book_price [ORDER_SLOTS];
    logic [23:0] book_qty [ORDER_SLOTS];
    bit          lvl_used [LEVEL_SLOTS];
    logic [40:0] lvl_key [LEVEL_SLOTS];
    logic [31:0] lvl_sum [LEVEL_SLOTS];
    logic [12:0] lvl_cnt [LEVEL_SLOTS];

    level_report_t expected_reports [$];

    int error_count = 0;
    int report_count = 0;
    int request_count = 0;
    longint cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;
    logic [7:0] rand_sym_max = 8'd255;
    logic [31:0] rand_price_max = 32'hFFFFFFFF;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int find_level(input logic [40:0] key);
        for (int i = 0; i < LEVEL_SLOTS; i++)
            if (lvl_used[i] && lvl_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int claim_level(input logic [40:0] key);
        int i;
        i = find_level(key);
        if (i >= 0)
            return i;
        for (i = 0; i < LEVEL_SLOTS; i++)
            if (!lvl_used[i])
            begin
                lvl_used[i] = 1'b1;
                lvl_key[i]  = key;
                lvl_sum[i]  = '0;
                lvl_cnt[i]  = '0;
                return i;
            end
        return -1;
    endfunction

    function automatic void push_report(input logic [1:0] st, input logic [40:0] key,
                                        input logic [31:0] total, input logic [12:0] orders,
                                        input logic last);
        level_report_t r;
        r.status = st;
        r.symbol = key[40:33];
        r.side   = key[32];
        r.price  = key[31:0];
        r.total  = total;
        r.orders = orders;
        r.last   = last;
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    function automatic void remove_from_level(input int id, input logic last);
        logic [40:0] key;
        int lv;
        logic [31:0] total;
        logic [12:0] orders;
        key = {book_symside[id], book_price[id]};
        lv = find_level(key);
        total = '0;
        orders = '0;
        if (lv >= 0)
        begin
            lvl_sum[lv] = (32'(book_qty[id]) > lvl_sum[lv]) ? 32'd0
                        : lvl_sum[lv] - 32'(book_qty[id]);
            if (lvl_cnt[lv] > 0)
                lvl_cnt[lv]--;
            total = lvl_sum[lv];
            orders = lvl_cnt[lv];
            if (orders == 0)
                lvl_used[lv] = 1'b0;
        end
        push_report(ST_OK, key, total, orders, last);
    endfunction

    function automatic void rest_on_level(input int id);
        logic [40:0] key;
        int lv;
        logic [32:0] s;
        key = {book_symside[id], book_price[id]};
        lv = claim_level(key);
        if (lv < 0)
        begin
            book_live[id] = 1'b0;
            push_report(ST_FULL, key, '0, '0, 1'b1);
            return;
        end
        s = {1'b0, lvl_sum[lv]} + 33'(book_qty[id]);
        lvl_sum[lv] = s[32] ? 32'hFFFFFFFF : s[31:0];
        lvl_cnt[lv]++;
        book_live[id] = 1'b1;
        push_report(ST_OK, key, lvl_sum[lv], lvl_cnt[lv], 1'b1);
    endfunction

    function automatic void predict_book(input logic [1:0] mode, input logic [7:0] sym,
                                         input logic sd, input logic [11:0] id,
                                         input logic [23:0] qty, input logic [31:0] px);
        logic [40:0] key;
        key = {sym, sd, px};
        if (mode == MODE_NONE)
            return;
        if (mode == MODE_ADD)
        begin
            if (book_live[id])
                push_report(ST_IN_USE, key, '0, '0, 1'b1);
            else if (claim_level(key) < 0)
                push_report(ST_FULL, key, '0, '0, 1'b1);
            else
            begin
                book_symside[id] = {sym, sd};
                book_price[id] = px;
                book_qty[id] = qty;
                rest_on_level(id);
            end
            return;
        end
        if (!book_live[id])
        begin
            push_report(ST_UNKNOWN, '0, '0, '0, 1'b1);
            return;
        end
        if (mode == MODE_DELETE)
        begin
            remove_from_level(id, 1'b1);
            book_live[id] = 1'b0;
            return;
        end
        remove_from_level(id, 1'b0);
        book_price[id] = px;
        book_qty[id] = qty;
        rest_on_level(id);
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [7:0] sym,
                                input logic sd, input logic [11:0] id,
                                input logic [23:0] qty, input logic [31:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.mode       <= mode;
        req.symbol     <= sym;
        req.side       <= sd;
        req.order_id   <= id;
        req.order_size <= qty;
        req.price      <= px;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_book(mode, sym, sd, id, qty, px);
        request_count++;
        @(negedge clk);
    endtask

    task automatic drain_book();
        req.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (2 * LEVEL_SLOTS + 20)
            @(negedge clk);
    endtask

    always @(negedge clk)
        rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        level_report_t want;
        cycle_count++;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            report_count++;
            if (expected_reports.size() == 0)
                report_mismatch("unexpected response", 32'd1, 32'd0);
            else
            begin
                want = expected_reports.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.level_symbol !== want.symbol)
                    report_mismatch("level_symbol", 32'(rsp.level_symbol), 32'(want.symbol));
                if (rsp.level_side !== want.side)
                    report_mismatch("level_side", 32'(rsp.level_side), 32'(want.side));
                if (rsp.level_price !== want.price)
                    report_mismatch("level_price", rsp.level_price, want.price);
                if (rsp.level_total !== want.total)
                    report_mismatch("level_total", rsp.level_total, want.total);
                if (rsp.level_orders !== want.orders)
                    report_mismatch("level_orders", 32'(rsp.level_orders), 32'(want.orders));
                if (rsp.last !== want.last)
                    report_mismatch("last", 32'(rsp.last), 32'(want.last));
            end
        end
        if (cycle_count > 10000000)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [11:0] pick_live_id();
        for (int t = 0; t < 8; t++)
        begin
            logic [11:0] id;
            id = 12'($urandom_range(ORDER_SLOTS - 1));
            if (book_live[id])
                return id;
        end
        return 12'($urandom_range(ORDER_SLOTS - 1));
    endfunction

    task automatic random_request();
        int pick;
        logic [1:0] mode;
        pick = $urandom_range(99);
        mode = (pick < 45) ? MODE_ADD : (pick < 70) ? MODE_MODIFY :
               (pick < 95) ? MODE_DELETE : MODE_NONE;
        send_request(mode, 8'($urandom_range(rand_sym_max)), 1'($urandom_range(1)),
                     (mode == MODE_ADD) ? 12'($urandom_range(ORDER_SLOTS - 1)) : pick_live_id(),
                     ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom),
                     ($urandom_range(9) == 0) ? $urandom : $urandom_range(rand_price_max));
    endtask

    task automatic test_directed();
        send_request(MODE_DELETE, 8'hFF, 1'b1, 12'hFFF, 24'hFFFFFF, 32'hFFFFFFFF);
        send_request(MODE_MODIFY, 8'd0, 1'b0, 12'd0, 24'd0, 32'd0);
        send_request(MODE_ADD, 8'hFF, 1'b1, 12'hFFF, 24'hFFFFFF, 32'hFFFFFFFF);
        send_request(MODE_ADD, 8'hFF, 1'b1, 12'hFFF, 24'd5, 32'd7);
        send_request(MODE_ADD, 8'hFF, 1'b1, 12'd1, 24'hFFFFFF, 32'hFFFFFFFF);
        for (int i = 2; i < 260; i++)
            send_request(MODE_ADD, 8'hFF, 1'b1, 12'(i), 24'hFFFFFF, 32'hFFFFFFFF);
        send_request(MODE_ADD, 8'd0, 1'b0, 12'd0, 24'd0, 32'd0);
        send_request(MODE_MODIFY, 8'd0, 1'b0, 12'd0, 24'd9, 32'd0);
        send_request(MODE_DELETE, 8'd0, 1'b0, 12'd0, 24'd0, 32'd0);
        send_request(MODE_NONE, 8'hAA, 1'b1, 12'd3, 24'd1, 32'd1);
        send_request(MODE_MODIFY, 8'd0, 1'b0, 12'hFFF, 24'd3, 32'd100);
    endtask

    task automatic test_level_table_full();
        for (int i = 0; i < LEVEL_SLOTS + 2; i++)
            send_request(MODE_ADD, 8'(i), 1'b0, 12'(1000 + i), 24'(i + 1), 32'(i));
        send_request(MODE_MODIFY, 8'd0, 1'b0, 12'd1000, 24'd4, 32'd99999);
        send_request(MODE_DELETE, 8'd0, 1'b0, 12'd1001, 24'd0, 32'd0);
        send_request(MODE_MODIFY, 8'd0, 1'b0, 12'd1002, 24'd4, 32'd99999);
        for (int i = 0; i < LEVEL_SLOTS + 2; i++)
            send_request(MODE_DELETE, 8'd0, 1'b0, 12'(1000 + i), 24'd0, 32'd0);
        for (int i = 0; i < 262; i++)
            send_request(MODE_DELETE, 8'd0, 1'b0, 12'(i), 24'd0, 32'd0);
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            rand_sym_max = ($urandom_range(3) == 0) ? 8'd255 : 8'd3;
            rand_price_max = ($urandom_range(3) == 0) ? 32'hFFFFFFFF : 32'd7;
            random_request();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000)
                    @(negedge clk);
                recv_hold = 1'b0;
            end
            test_random(20, 0, 0);
        join
    endtask

    initial
    begin
        req.valid      = 1'b0;
        req.mode       = MODE_NONE;
        req.symbol     = '0;
        req.side       = 1'b0;
        req.order_id   = '0;
        req.order_size = '0;
        req.price      = '0;
        rsp.ready      = 1'b0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_level_table_full();
        test_random(250, 24, 72);
        test_random(250, 72, 24);
        test_backpressure();
        test_random(180, 0, 0);
        drain_book();
        $display("Covered %0d requests and %0d responses: errors, full level table,",
                 request_count, report_count);
        $display("saturation, modifies, idle mixes and a long response stall.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/plob_pkg.sv
hw/rtl/plob_if.sv
hw/rtl/plob_ctrl.sv
hw/rtl/plob_dp.sv
hw/rtl/price_level_order_book.sv
hw/rtl/plob_chk.sv
tb/sv/testbench.sv
